[rtl/ftc_pkg.sv]
// Package for the fridge thermostat controller: mode and event codes, register
// indexes, reset values and the structs shared by the configuration, control and top files.
// No dependencies.
package ftc_pkg;

	typedef enum logic [1:0] {
		MODE_DELAY   = 2'd0,
		MODE_MONITOR = 2'd1,
		MODE_TUNING  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_BUTTON = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		CFG_ON_THRESHOLD = 3'd0,
		CFG_OFF_MIN      = 3'd1,
		CFG_OFF_MAX      = 3'd2,
		CFG_OFF_INITIAL  = 3'd3,
		CFG_TEMP_OFFSET  = 3'd4,
		CFG_DELAY_TICKS  = 3'd5,
		CFG_TUNE_PERIOD  = 3'd6
	} cfg_index_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned ADC_W       = 10;

	localparam logic signed [7:0] ON_THRESHOLD_RST = 8'sd8;
	localparam logic signed [7:0] OFF_MIN_RST      = 8'sd0;
	localparam logic signed [7:0] OFF_MAX_RST      = 8'sd6;
	localparam logic signed [7:0] OFF_INITIAL_RST  = 8'sd3;
	localparam logic signed [7:0] TEMP_OFFSET_RST  = 8'sd0;
	localparam logic [15:0]       DELAY_TICKS_RST  = 16'd600;
	localparam logic [7:0]        TUNE_PERIOD_RST  = 8'd3;

	// The LED blinks on each of the last ticks of the delay countdown.
	localparam logic [15:0] BLINK_LAST = 16'd20;

	typedef struct packed {
		logic signed [7:0] on_threshold;
		logic signed [7:0] off_min;
		logic signed [7:0] off_max;
		logic signed [7:0] temp_offset;
		logic [15:0]       delay_ticks;
		logic [7:0]        tune_period;
	} cfg_t;

	typedef struct packed {
		logic              motor_on;
		logic              led_on;
		mode_t             mode;
		logic signed [7:0] off_threshold;
		logic              save_strobe;
		logic signed [7:0] temperature;
	} result_t;

endpackage

[rtl/ftc_cfg_regs.sv]
// Configuration register file of the fridge thermostat controller.
// Depends on ftc_pkg for register indexes, reset values and cfg_t.
module ftc_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [ftc_pkg::CFG_INDEX_W-1:0]      wr_index,
	input  logic [ftc_pkg::CFG_DATA_W-1:0]       wr_data,
	output ftc_pkg::cfg_t                        cfg
);

	ftc_pkg::cfg_t cfg_q;

	// The initial off threshold only counts at reset, so a write to it is
	// accepted and dropped, as are writes beyond the last register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_threshold <= ftc_pkg::ON_THRESHOLD_RST;
			cfg_q.off_min      <= ftc_pkg::OFF_MIN_RST;
			cfg_q.off_max      <= ftc_pkg::OFF_MAX_RST;
			cfg_q.temp_offset  <= ftc_pkg::TEMP_OFFSET_RST;
			cfg_q.delay_ticks  <= ftc_pkg::DELAY_TICKS_RST;
			cfg_q.tune_period  <= ftc_pkg::TUNE_PERIOD_RST;
		end else if (wr_en) begin
			case (ftc_pkg::cfg_index_t'(wr_index))
				ftc_pkg::CFG_ON_THRESHOLD: cfg_q.on_threshold <= wr_data[7:0];
				ftc_pkg::CFG_OFF_MIN:      cfg_q.off_min      <= wr_data[7:0];
				ftc_pkg::CFG_OFF_MAX:      cfg_q.off_max      <= wr_data[7:0];
				ftc_pkg::CFG_TEMP_OFFSET:  cfg_q.temp_offset  <= wr_data[7:0];
				ftc_pkg::CFG_DELAY_TICKS:  cfg_q.delay_ticks  <= wr_data[15:0];
				ftc_pkg::CFG_TUNE_PERIOD:  cfg_q.tune_period  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/ftc_temp_conv.sv]
// ADC to temperature conversion: divide by a constant, add the offset, saturate.
// Depends on ftc_pkg for the ADC width.
module ftc_temp_conv #(
	parameter int unsigned ADC_DIVISOR = 8
) (
	input  logic [ftc_pkg::ADC_W-1:0] adc_value,
	input  logic signed [7:0]         temp_offset,
	output logic signed [7:0]         temperature
);

	// Reciprocal with a 16-bit shift is exact for every 10-bit reading and a
	// divisor up to 64.
	localparam int unsigned SHIFT = 16;
	localparam int unsigned RECIP = ((2 ** SHIFT) + ADC_DIVISOR - 1) / ADC_DIVISOR;
	localparam int unsigned PROD_W = ftc_pkg::ADC_W + SHIFT + 1;

	logic [SHIFT:0]              recip;
	logic [PROD_W-1:0]           prod;
	logic [ftc_pkg::ADC_W-1:0]   quot;
	logic signed [11:0]          sum;

	assign recip = (SHIFT + 1)'(RECIP);
	assign prod  = PROD_W'(adc_value) * PROD_W'(recip);
	assign quot  = prod[SHIFT +: ftc_pkg::ADC_W];
	assign sum   = $signed({2'b00, quot}) + $signed({{4{temp_offset[7]}}, temp_offset});

	always_comb begin
		if (sum > 12'sd127) begin
			temperature = 8'sd127;
		end else if (sum < -12'sd128) begin
			temperature = -8'sd128;
		end else begin
			temperature = sum[7:0];
		end
	end

endmodule

[rtl/ftc_ctrl.sv]
// Thermostat control state: mode, countdowns, threshold, motor, LED and temperature.
// Depends on ftc_pkg for mode_t, action_t, cfg_t and result_t.
module ftc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  ftc_pkg::action_t    action,
	input  logic signed [7:0]   sample_temp,
	input  ftc_pkg::cfg_t       cfg,
	output ftc_pkg::result_t    result
);

	ftc_pkg::mode_t     mode_q, mode_d;
	logic [15:0]        count_q, count_d;
	logic [7:0]         period_cnt_q, period_cnt_d;
	logic signed [7:0]  thr_q, thr_d;
	logic               motor_q, motor_d;
	logic               led_q, led_d;
	logic signed [7:0]  temp_q, temp_d;
	logic               save;

	logic               is_tick, is_sample, is_button;
	logic [15:0]        count_dec;
	logic [7:0]         period;
	logic [7:0]         period_inc;
	logic               period_done;
	logic               tune_end;
	logic               below_off, above_on;
	logic signed [8:0]  thr_dec;
	logic signed [7:0]  thr_new;
	logic [8:0]         thr_mag;

	assign is_tick   = (action == ftc_pkg::ACT_TICK);
	assign is_sample = (action == ftc_pkg::ACT_SAMPLE);
	assign is_button = (action == ftc_pkg::ACT_BUTTON);

	assign count_dec   = (count_q != 16'd0) ? count_q - 16'd1 : 16'd0;
	assign period      = (cfg.tune_period == 8'd0) ? 8'd1 : cfg.tune_period;
	assign period_inc  = period_cnt_q + 8'd1;
	assign period_done = (period_inc >= period);
	// The tuning display ends when the count is empty after a period expiry.
	assign tune_end    = period_done && (count_dec == 16'd0);

	assign below_off = (sample_temp < thr_q);
	assign above_on  = (sample_temp > cfg.on_threshold);

	assign thr_dec = $signed({thr_q[7], thr_q}) - 9'sd1;
	assign thr_new = (thr_dec < $signed({cfg.off_min[7], cfg.off_min})) ? cfg.off_max
	               : thr_dec[7:0];
	assign thr_mag = thr_new[7] ? 9'd0 - {thr_new[7], thr_new} : {1'b0, thr_new};

	// Next mode.
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			ftc_pkg::MODE_DELAY: begin
				if (is_tick && count_dec == 16'd0) begin
					mode_d = ftc_pkg::MODE_MONITOR;
				end else if (is_button) begin
					mode_d = ftc_pkg::MODE_TUNING;
				end
			end
			ftc_pkg::MODE_MONITOR: begin
				if (is_sample && below_off) begin
					mode_d = ftc_pkg::MODE_DELAY;
				end else if (is_button) begin
					mode_d = ftc_pkg::MODE_TUNING;
				end
			end
			ftc_pkg::MODE_TUNING: begin
				if (is_tick && tune_end) begin
					mode_d = ftc_pkg::MODE_DELAY;
				end
			end
			default: mode_d = ftc_pkg::MODE_DELAY;
		endcase
	end

	// Datapath registers and the save strobe.
	always_comb begin
		count_d      = count_q;
		period_cnt_d = period_cnt_q;
		thr_d        = thr_q;
		motor_d      = motor_q;
		led_d        = led_q;
		temp_d       = temp_q;
		save         = 1'b0;
		case (action)
			ftc_pkg::ACT_TICK: begin
				if (mode_q == ftc_pkg::MODE_DELAY) begin
					count_d = count_dec;
					if (count_dec <= ftc_pkg::BLINK_LAST) begin
						led_d = ~led_q;
					end
				end else if (mode_q == ftc_pkg::MODE_TUNING) begin
					if (period_done) begin
						period_cnt_d = 8'd0;
						count_d      = count_dec;
						if (count_q != 16'd0) begin
							led_d = ~led_q;
						end
						if (tune_end) begin
							motor_d = 1'b0;
							led_d   = 1'b0;
							count_d = cfg.delay_ticks;
						end
					end else begin
						period_cnt_d = period_inc;
					end
				end
			end
			ftc_pkg::ACT_SAMPLE: begin
				temp_d = sample_temp;
				if (mode_q == ftc_pkg::MODE_MONITOR) begin
					led_d = ~led_q;
					if (below_off) begin
						motor_d = 1'b0;
						led_d   = 1'b0;
						count_d = cfg.delay_ticks;
					end else if (above_on) begin
						motor_d = 1'b1;
					end
				end
			end
			ftc_pkg::ACT_BUTTON: begin
				if (mode_q != ftc_pkg::MODE_TUNING) begin
					thr_d        = thr_new;
					save         = 1'b1;
					led_d        = 1'b0;
					count_d      = {6'd0, thr_mag, 1'b0};
					period_cnt_d = 8'd0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ftc_pkg::MODE_DELAY;
			count_q      <= ftc_pkg::DELAY_TICKS_RST;
			period_cnt_q <= 8'd0;
			thr_q        <= ftc_pkg::OFF_INITIAL_RST;
			motor_q      <= 1'b0;
			led_q        <= 1'b0;
			temp_q       <= 8'sd0;
		end else if (step) begin
			mode_q       <= mode_d;
			count_q      <= count_d;
			period_cnt_q <= period_cnt_d;
			thr_q        <= thr_d;
			motor_q      <= motor_d;
			led_q        <= led_d;
			temp_q       <= temp_d;
		end
	end

	assign result.motor_on      = motor_d;
	assign result.led_on        = led_d;
	assign result.mode          = mode_d;
	assign result.off_threshold = thr_d;
	assign result.save_strobe   = save;
	assign result.temperature   = temp_d;

endmodule

[rtl/fridge_thermostat_controller_unit.sv]
// Top level of the fridge thermostat controller.
// Depends on ftc_pkg, ftc_cfg_regs, ftc_temp_conv and ftc_ctrl.
//
// Usage:
// Events arrive on the s_ channel: s_tuser carries the event kind (tick, ADC
// sample or button press) and s_tdata the 10-bit ADC reading, which matters
// only for samples. Every accepted transaction yields exactly one status
// transaction on the m_ channel with the motor drive, LED level, mode, off
// threshold, save strobe and last temperature after that event.
// The cfg_ channel writes the six registers by index; it is always ready and
// should be used only while no event is in flight.
// An event is captured in an input stage, and its status is registered in the
// output register once that register is empty or drained. Throughput is one event
// per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its transaction and the
// input stage can still take one more event; further events wait on s_tready.
// Reset clears both stages, puts the block in delay mode with the motor and
// LED off, loads the delay countdown and the initial off threshold, and
// returns the configuration registers to their reset values.
module fridge_thermostat_controller_unit #(
	parameter int unsigned ADC_DIVISOR = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Event stream.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [15:0]                          s_tdata,  // [9:0] adc_value
	input  logic [1:0]                           s_tuser,  // [1:0] action
	// Status stream.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] motor_on, [1] led_on, [3:2] mode, [11:4] off_threshold,
	// [12] save_strobe, [20:13] temperature, [23:21] zero
	output logic [23:0]                          m_tdata,
	// Configuration writes.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ftc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [ftc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic                          valid_s1;
	ftc_pkg::action_t              action_s1;
	logic [ftc_pkg::ADC_W-1:0]     adc_s1;

	logic                          out_valid_q;
	ftc_pkg::result_t              out_q;

	logic                          advance;
	logic                          step;
	ftc_pkg::cfg_t                 cfg;
	logic signed [7:0]             sample_temp;
	ftc_pkg::result_t              result;

	// The pipeline moves whenever the output register is empty or drained.
	assign advance  = !out_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	ftc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ftc_temp_conv #(
		.ADC_DIVISOR (ADC_DIVISOR)
	) u_conv (
		.adc_value   (adc_s1),
		.temp_offset (cfg.temp_offset),
		.temperature (sample_temp)
	);

	ftc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.action      (action_s1),
		.sample_temp (sample_temp),
		.cfg         (cfg),
		.result      (result)
	);

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= ftc_pkg::action_t'(s_tuser);
			adc_s1    <= s_tdata[ftc_pkg::ADC_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.temperature, out_q.save_strobe, out_q.off_threshold,
	                   out_q.mode, out_q.led_on, out_q.motor_on};

	// A save strobe only accompanies the entry into tuning.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.save_strobe |-> out_q.mode == ftc_pkg::MODE_TUNING)
		else $error("save strobe outside tuning mode");

	// The compressor is never driven in delay mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.mode == ftc_pkg::MODE_DELAY |-> !out_q.motor_on)
		else $error("motor on in delay mode");

	// A held input stage keeps its event until the pipeline moves.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(action_s1) && $stable(adc_s1))
		else $error("input stage lost or changed a waiting event");

endmodule

[tb/sv/fridge_thermostat_controller_unit_tb.sv]
// Self-checking testbench for fridge_thermostat_controller_unit: directed and random events,
// with random gaps and stalls on both streams, each status checked against an in-bench model.
// Depends on ftc_pkg and the RTL of the controller.
module fridge_thermostat_controller_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ftc_pkg::*;

	localparam int ADC_DIV = 8;
	// Index past the last register; writes to it must leave every register alone.
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_IDX = 3'd7;

	typedef struct {
		action_t    act;
		logic [9:0] adc;
	} thermo_ev_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [15:0]            s_tdata = '0;  // [9:0] adc_value
	logic [1:0]             s_tuser = '0;  // [1:0] action
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [0] motor_on, [1] led_on, [3:2] mode, [11:4] off_threshold,
	// [12] save_strobe, [20:13] temperature
	logic [23:0]            m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Register shadows, updated on each accepted configuration transaction.
	logic signed [7:0] k_on_thr = ON_THRESHOLD_RST;
	logic signed [7:0] k_off_min = OFF_MIN_RST;
	logic signed [7:0] k_off_max = OFF_MAX_RST;
	logic signed [7:0] k_off_init = OFF_INITIAL_RST;
	logic signed [7:0] k_offset = TEMP_OFFSET_RST;
	logic [15:0]       k_delay = DELAY_TICKS_RST;
	logic [7:0]        k_period = TUNE_PERIOD_RST;

	// Controller state as the bench expects it to be after every accepted event.
	mode_t             ctl_mode = MODE_DELAY;
	logic [15:0]       ctl_count = DELAY_TICKS_RST;
	logic [7:0]        ctl_phase = '0;
	logic signed [7:0] ctl_thr = OFF_INITIAL_RST;
	logic              ctl_motor = 1'b0;
	logic              ctl_led = 1'b0;
	logic signed [7:0] ctl_temp = '0;

	thermo_ev_t  ev_backlog[$];   // events not yet offered on the event stream
	result_t     status_due[$];   // predicted status, oldest first
	result_t     got, want;

	bit          in_taken = 1'b0;
	bit          out_taken = 1'b0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	int          sent_cnt = 0;
	int          got_cnt = 0;
	int          err_cnt = 0;

	fridge_thermostat_controller_unit #(
		.ADC_DIVISOR(ADC_DIV)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Delay mode always starts with the compressor and LED off and a full countdown.
	function automatic void go_delay();
		ctl_mode = MODE_DELAY;
		ctl_motor = 1'b0;
		ctl_led = 1'b0;
		ctl_count = k_delay;
	endfunction

	function automatic void store_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
		case (idx)
			CFG_ON_THRESHOLD: k_on_thr = val[7:0];
			CFG_OFF_MIN:      k_off_min = val[7:0];
			CFG_OFF_MAX:      k_off_max = val[7:0];
			CFG_OFF_INITIAL:  k_off_init = val[7:0];
			CFG_TEMP_OFFSET:  k_offset = val[7:0];
			CFG_DELAY_TICKS:  k_delay = val;
			CFG_TUNE_PERIOD:  k_period = val[7:0];
			default: ;
		endcase
	endfunction

	// Advances the expected state by one event and returns the status it should produce.
	function automatic result_t thermo_step(action_t act, logic [9:0] adc);
		int         t;
		logic [7:0] per;
		result_t    r;
		r.save_strobe = 1'b0;
		case (act)
			ACT_TICK: begin
				if (ctl_mode == MODE_DELAY) begin
					if (ctl_count != 0)
						ctl_count--;
					if (ctl_count <= BLINK_LAST)
						ctl_led = ~ctl_led;
					if (ctl_count == 0)
						ctl_mode = MODE_MONITOR;
				end else if (ctl_mode == MODE_TUNING) begin
					// A tuning period of zero behaves as one tick.
					per = (k_period == 0) ? 8'd1 : k_period;
					ctl_phase++;
					if (ctl_phase >= per) begin
						ctl_phase = '0;
						if (ctl_count != 0) begin
							ctl_led = ~ctl_led;
							ctl_count--;
						end
						if (ctl_count == 0)
							go_delay();
					end
				end
			end
			ACT_SAMPLE: begin
				// Temperature is always updated; only monitor mode reacts to it.
				t = int'(adc) / ADC_DIV + int'(k_offset);
				if (t > 127)
					t = 127;
				if (t < -128)
					t = -128;
				ctl_temp = t[7:0];
				if (ctl_mode == MODE_MONITOR) begin
					ctl_led = ~ctl_led;
					if (ctl_temp < ctl_thr)
						go_delay();
					else if (ctl_temp > k_on_thr)
						ctl_motor = 1'b1;
				end
			end
			ACT_BUTTON: begin
				// Presses while tuning are ignored.
				if (ctl_mode != MODE_TUNING) begin
					t = int'(ctl_thr) - 1;
					if (t < int'(k_off_min))
						t = int'(k_off_max);
					ctl_thr = t[7:0];
					r.save_strobe = 1'b1;
					ctl_led = 1'b0;
					ctl_mode = MODE_TUNING;
					ctl_count = 16'(t < 0 ? -2 * t : 2 * t);
					ctl_phase = '0;
				end
			end
			default: ;
		endcase
		r.motor_on = ctl_motor;
		r.led_on = ctl_led;
		r.mode = ctl_mode;
		r.off_threshold = ctl_thr;
		r.temperature = ctl_temp;
		return r;
	endfunction

	function automatic result_t unpack_status(logic [23:0] d);
		result_t r;
		r.motor_on = d[0];
		r.led_on = d[1];
		r.mode = mode_t'(d[3:2]);
		r.off_threshold = d[11:4];
		r.save_strobe = d[12];
		r.temperature = d[20:13];
		return r;
	endfunction

	// Event driver. Inputs move on the falling edge; in_taken is set by the monitor at the
	// rising edge where the transaction completed. Every 60 events out of 240 go without gaps.
	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (in_taken) begin
				in_taken = 1'b0;
				tx_wait = ((sent_cnt / 60) % 4 == 1) ? 0 : $urandom_range(0, 17);
			end
			if (tx_wait > 0 || ev_backlog.size() == 0) begin
				if (tx_wait > 0)
					tx_wait--;
				s_tvalid <= 1'b0;
			end else begin
				s_tuser <= ev_backlog[0].act;
				s_tdata <= {6'd0, ev_backlog[0].adc};
				s_tvalid <= 1'b1;
				void'(ev_backlog.pop_front());
				sent_cnt++;
			end
		end
	end

	// Status receiver: after each transaction it draws a stall, with stall-free stretches.
	always @(negedge clk) begin
		if (out_taken) begin
			out_taken = 1'b0;
			rx_wait = ((got_cnt / 45) % 4 == 2) ? 0 : $urandom_range(0, 17);
		end
		if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: tracks register writes, predicts each accepted event and checks each status.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				store_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				in_taken = 1'b1;
				status_due.push_back(thermo_step(action_t'(s_tuser), s_tdata[9:0]));
			end
			if (m_tvalid && m_tready) begin
				out_taken = 1'b1;
				got_cnt++;
				got = unpack_status(m_tdata);
				if (status_due.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: status %h arrived with nothing outstanding",
							$time, m_tdata);
				end else begin
					want = status_due.pop_front();
					if (got.motor_on !== want.motor_on || got.led_on !== want.led_on
						|| got.mode !== want.mode
						|| got.off_threshold !== want.off_threshold
						|| got.save_strobe !== want.save_strobe
						|| got.temperature !== want.temperature) begin
						err_cnt++;
						if (err_cnt <= 10) begin
							$write("%0t: status %0d expected/actual: motor %b/%b led %b/%b",
								$time, got_cnt, want.motor_on, got.motor_on, want.led_on,
								got.led_on);
							$display(" mode %0d/%0d thr %0d/%0d save %b/%b temp %0d/%0d",
								want.mode, got.mode, want.off_threshold,
								got.off_threshold, want.save_strobe, got.save_strobe,
								want.temperature, got.temperature);
						end
					end
				end
			end
		end
	end

	function automatic logic [9:0] rand_adc();
		return 10'($urandom);
	endfunction

	task automatic push_ev(action_t a, logic [9:0] v);
		thermo_ev_t e;
		e.act = a;
		e.adc = v;
		ev_backlog.push_back(e);
	endtask

	task automatic tick_run(int n);
		repeat (n) push_ev(ACT_TICK, rand_adc());
	endtask

	// Half the samples land a few degrees around one of the thresholds, the rest anywhere.
	task automatic sample_ev();
		int tgt, raw;
		if ($urandom_range(0, 1) == 0) begin
			push_ev(ACT_SAMPLE, rand_adc());
		end else begin
			case ($urandom_range(0, 3))
				0: tgt = k_on_thr;
				1: tgt = k_off_min;
				2: tgt = k_off_max;
				default: tgt = ctl_thr;
			endcase
			raw = (tgt + int'($urandom_range(0, 6)) - 3 - int'(k_offset)) * ADC_DIV
				+ int'($urandom_range(0, ADC_DIV - 1));
			if (raw < 0)
				raw = 0;
			if (raw > 1023)
				raw = 1023;
			push_ev(ACT_SAMPLE, raw[9:0]);
		end
	endtask

	// Waits until every queued event went out and its status came back, then lets the
	// pipeline settle so a register write cannot overlap an event.
	task automatic drain();
		do
			@(posedge clk);
		while (ev_backlog.size() != 0 || s_tvalid || status_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Writes all seven register indexes; the unused upper byte of 8-bit registers carries junk.
	task automatic load_cfg(int on_t, int omin, int omax, int oinit, int offs, int dly, int per);
		write_reg(CFG_ON_THRESHOLD, {8'($urandom), 8'(on_t)});
		write_reg(CFG_OFF_MIN, {8'($urandom), 8'(omin)});
		write_reg(CFG_OFF_MAX, {8'($urandom), 8'(omax)});
		write_reg(CFG_OFF_INITIAL, {8'($urandom), 8'(oinit)});
		write_reg(CFG_TEMP_OFFSET, {8'($urandom), 8'(offs)});
		write_reg(CFG_DELAY_TICKS, 16'(dly));
		write_reg(CFG_TUNE_PERIOD, {8'($urandom), 8'(per)});
	endtask

	// Random traffic built from tick runs of random length, sample bursts,
	// button presses and a share of unstructured events.
	task automatic random_phase(int n);
		int made, r, len;
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				len = $urandom_range(1, 30);
				tick_run(len);
			end else if (r < 75) begin
				len = $urandom_range(1, 6);
				repeat (len) sample_ev();
			end else if (r < 88) begin
				len = 1;
				push_ev(ACT_BUTTON, rand_adc());
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) push_ev(action_t'($urandom_range(0, 2)), rand_adc());
			end
			made += len;
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: samples at both ends of the converter range while in delay, a press
		// that starts tuning, a second press that must be ignored, then the tuning blinks
		// run out at a three-tick period and the block falls back to delay.
		push_ev(ACT_SAMPLE, 10'd0);
		push_ev(ACT_SAMPLE, 10'd1023);
		push_ev(ACT_TICK, rand_adc());
		push_ev(ACT_BUTTON, rand_adc());
		push_ev(ACT_BUTTON, rand_adc());
		push_ev(ACT_SAMPLE, 10'd512);
		tick_run(12);
		drain();

		// Zero tuning period acts as one tick, temperature saturates high, a tick in monitor
		// changes nothing, the motor turns on, and a threshold of zero leaves tuning at once.
		load_cfg(10, -128, 127, -5, 127, 1, 0);
		write_reg(CFG_SPARE_IDX, 16'hA5C3);
		push_ev(ACT_BUTTON, rand_adc());
		push_ev(ACT_SAMPLE, 10'd1023);
		tick_run(3);
		push_ev(ACT_TICK, rand_adc());
		push_ev(ACT_SAMPLE, 10'd0);
		push_ev(ACT_BUTTON, rand_adc());
		tick_run(2);
		drain();

		// Lowest offset and thresholds: cold samples return to delay, a zero delay leaves it
		// on the first tick, and a press wraps the threshold to -128, the longest blink count.
		load_cfg(-128, 127, -128, 127, -128, 0, 1);
		push_ev(ACT_SAMPLE, 10'd0);
		push_ev(ACT_TICK, rand_adc());
		push_ev(ACT_SAMPLE, 10'd1023);
		push_ev(ACT_TICK, rand_adc());
		push_ev(ACT_BUTTON, rand_adc());
		tick_run(257);
		push_ev(ACT_SAMPLE, 10'd1023);
		drain();

		// Stepping down from -128 wraps to the maximum.
		load_cfg(-128, -128, 2, 0, -128, 0, 1);
		push_ev(ACT_BUTTON, rand_adc());
		tick_run(6);
		drain();

		load_cfg(8, 0, 6, 3, 0, 10, 2);
		random_phase(90);
		load_cfg(20, -10, 10, 0, -20, 25, 1);
		random_phase(90);
		load_cfg(127, -128, 127, -128, 127, 0, 255);
		random_phase(50);
		load_cfg(-128, 127, -20, 127, -128, 65535, 1);
		random_phase(50);

		// The previous settings can leave a long tuning display or the longest delay; run
		// out the one and cut the other short with a press before the next random part.
		load_cfg(5, -3, 4, 1, -40, 3, 1);
		tick_run(45);
		push_ev(ACT_BUTTON, rand_adc());
		tick_run(12);
		random_phase(100);
		load_cfg(0, -2, 2, 0, 0, 5, 3);
		random_phase(90);
		load_cfg(50, 30, 60, 0, 40, 15, 2);
		random_phase(80);

		drain();
		if (err_cnt == 0 && status_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
rtl/ftc_pkg.sv
rtl/ftc_cfg_regs.sv
rtl/ftc_temp_conv.sv
rtl/ftc_ctrl.sv
rtl/fridge_thermostat_controller_unit.sv
tb/sv/fridge_thermostat_controller_unit_tb.sv
